>>> sv/qfd_pkg.sv
// Shared types and constants for the Q16.16 fixed-point divider.
package qfd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	// one quotient bit per cell: integer part plus fraction
	localparam int NUM_W     = DATA_W + FRAC_BITS;
	// start edge to the edge that takes the done strobe: entry, cells, result register
	localparam int LATENCY   = NUM_W + 2;

	localparam logic [DATA_W-1:0] SIGN_VAL   = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] MAXPOS_VAL = {1'b0, {(DATA_W-1){1'b1}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] dividend;
		logic signed [DATA_W-1:0] divisor;
	} operand_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] quotient;
		logic                     divide_by_zero;
		logic                     overflow;
	} result_t;

	// payload handed from cell to cell
	typedef struct packed {
		logic              neg;
		logic              dbz;
		logic [DATA_W-1:0] divisor;
		logic [DATA_W-1:0] rem;
		logic [NUM_W-1:0]  num;
	} stage_t;

endpackage

>>> sv/qfd_prep.sv
// Entry stage: operand signs, magnitudes and zero-divisor detect.
module qfd_prep import qfd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  operand_t operands,
	output logic     out_valid,
	output stage_t   out_stage
);

	logic              a_neg;
	logic              b_neg;
	logic [DATA_W-1:0] ua;
	logic [DATA_W-1:0] ub;
	logic              valid_q;
	stage_t            stage_q;

	assign a_neg = operands.dividend[DATA_W-1];
	assign b_neg = operands.divisor[DATA_W-1];
	// most negative value maps onto 2^31 unsigned
	assign ua = a_neg ? DATA_W'(-operands.dividend) : DATA_W'(operands.dividend);
	assign ub = b_neg ? DATA_W'(-operands.divisor) : DATA_W'(operands.divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		stage_q.neg     <= a_neg ^ b_neg;
		stage_q.dbz     <= (ub == '0);
		stage_q.divisor <= ub;
		stage_q.rem     <= '0;
		stage_q.num     <= {ua, {FRAC_BITS{1'b0}}};
	end

	assign out_valid = valid_q;
	assign out_stage = stage_q;

endmodule

>>> sv/qfd_cell.sv
// One restoring shift-subtract step: produces one quotient bit.
module qfd_cell import qfd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  stage_t in_stage,
	output logic   out_valid,
	output stage_t out_stage
);

	logic [DATA_W:0] shifted;
	logic [DATA_W:0] diff;
	logic            qbit;
	logic            valid_q;
	stage_t          stage_q;

	// bring down the next numerator bit and try the subtract
	assign shifted = {in_stage.rem, in_stage.num[NUM_W-1]};
	assign diff    = shifted - {1'b0, in_stage.divisor};
	assign qbit    = ~diff[DATA_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		stage_q.neg     <= in_stage.neg;
		stage_q.dbz     <= in_stage.dbz;
		stage_q.divisor <= in_stage.divisor;
		stage_q.rem     <= qbit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
		// quotient bits fill in from the bottom as numerator bits leave the top
		stage_q.num     <= {in_stage.num[NUM_W-2:0], qbit};
	end

	assign out_valid = valid_q;
	assign out_stage = stage_q;

endmodule

>>> sv/qfd_post.sv
// Exit stage: sign, overflow flag and zero-divisor saturation into the result register.
module qfd_post import qfd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  stage_t  in_stage,
	output logic    done,
	output result_t result
);

	logic [DATA_W-1:0] mag;
	logic              ovf;
	result_t           res_d;
	logic              done_q;
	result_t           result_q;

	assign mag = in_stage.num[DATA_W-1:0];
	assign ovf = |in_stage.num[NUM_W-1:DATA_W];

	always_comb begin
		if (in_stage.dbz) begin
			res_d.quotient       = in_stage.neg ? SIGN_VAL : MAXPOS_VAL;
			res_d.divide_by_zero = 1'b1;
			res_d.overflow       = 1'b0;
		end else begin
			res_d.quotient       = in_stage.neg ? DATA_W'(-mag) : mag;
			res_d.divide_by_zero = 1'b0;
			res_d.overflow       = ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> sv/q16_fixed_point_divider.sv
// Top level of the pipelined Q16.16 fixed-point divider.
// Signed Q16.16 divide: quotient = (|dividend| << 16) / |divisor|, truncated toward zero,
// low 32 bits kept, sign from the XOR of operand signs. A new operand pair may be started
// every cycle (busy stays low); its result appears on result with a one-cycle done strobe
// after passing one entry stage, one cell per quotient bit through a row of 48 restoring
// subtract cells, and one result register. Results come in start order and cannot be held
// off, so take each one when done is high. A zero divisor returns 0x7FFFFFFF, or 0x80000000
// for a negative dividend, with divide_by_zero set; a quotient that needs more than 32 bits
// wraps and sets overflow.
module q16_fixed_point_divider import qfd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  operand_t operands,
	output logic     done,
	output result_t  result
);

	logic   valid_s [NUM_W+1];
	stage_t stage_s [NUM_W+1];

	assign busy = 1'b0;

	qfd_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.operands  (operands),
		.out_valid (valid_s[0]),
		.out_stage (stage_s[0])
	);

	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		qfd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_s[i]),
			.in_stage  (stage_s[i]),
			.out_valid (valid_s[i+1]),
			.out_stage (stage_s[i+1])
		);
	end

	qfd_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s[NUM_W]),
		.in_stage (stage_s[NUM_W]),
		.done     (done),
		.result   (result)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(LATENCY) done)
		else $error("accepted beat did not produce a result on time");

	a_dbz_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.divide_by_zero |-> !result.overflow)
		else $error("overflow raised together with divide by zero");

	a_dbz_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.divide_by_zero |->
			(result.quotient == SIGN_VAL) || (result.quotient == MAXPOS_VAL))
		else $error("divide by zero result not saturated");

endmodule
